/* hw/rtl/wmr_pkg.sv */
package wmr_pkg;

   localparam int SYM_W = 8;
   localparam int ACT_W = 2;

   localparam logic [SYM_W-1:0] STAR_SYM  = 8'd42;
   localparam logic [SYM_W-1:0] QMARK_SYM = 8'd63;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_TEXT   = 2'd2,
      ACT_END    = 2'd3
   } act_type;

   // broadcast from the control to every cell of the row
   typedef struct packed {
      logic             step;
      logic             load;
      logic [SYM_W-1:0] sym;
   } cell_ctrl_type;

endpackage

/* hw/rtl/wildcard_match_row_update.sv */
// Glob matcher over a byte stream: the pattern ('*' any run, '?' any one byte) is
// loaded with append beats and held in a row of PATTERN_MAX cells, one per
// pattern position, each keeping its pattern byte and one reachability bit.
// Beats are taken one per clock for every action, save that an end-of-text
// beat waits only while the previous result has not been taken yet; a text
// byte updates the whole row when it is taken, and an end-of-text beat loads
// a result (matched, overflowed) into the output register. The clock is bounded
// by the ripple through a run of star cells, which works like a carry chain of
// PATTERN_MAX single OR gates. Appends beyond PATTERN_MAX are dropped and
// reported through overflowed until the next clear. Any append or clear
// abandons the text in progress.
module wildcard_match_row_update
   import wmr_pkg::*;
#(
   parameter int PATTERN_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] overflowed, [7:2] zero
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PATTERN_MAX);

   act_type            act;
   logic               fire;

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   lead_ff, lead_in;
   logic               all_star_ff, all_star_in;
   logic               ovf_ff, ovf_in;
   logic               reach0_ff, reach0_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_match_ff;
   logic               rsp_ovf_ff;

   cell_ctrl_type      ctrl;
   logic               append_ok;
   logic [PATTERN_MAX:0] row;
   logic [PATTERN_MAX:0] carry;
   logic               match_now;

   assign act        = act_type'(req_tuser);
   assign req_tready = !rsp_valid_ff || rsp_tready || (act != ACT_END);
   assign fire       = req_tvalid && req_tready;
   assign append_ok  = (len_ff != LEN_FULL);

   always_comb begin
      len_in      = len_ff;
      lead_in     = lead_ff;
      all_star_in = all_star_ff;
      ovf_in      = ovf_ff;
      ctrl.step   = 1'b0;
      ctrl.load   = 1'b0;
      ctrl.sym    = req_tdata;
      if (fire) begin
         unique case (act)
            ACT_CLEAR: begin
               len_in      = '0;
               lead_in     = '0;
               all_star_in = 1'b1;
               ovf_in      = 1'b0;
               ctrl.load   = 1'b1;
            end
            ACT_APPEND: begin
               if (append_ok) begin
                  len_in = len_ff + LEN_W'(1);
                  if (all_star_ff && (req_tdata == STAR_SYM)) begin
                     lead_in = lead_ff + LEN_W'(1);
                  end else begin
                     all_star_in = 1'b0;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               ctrl.load = 1'b1;
            end
            ACT_TEXT: begin
               ctrl.step = 1'b1;
            end
            ACT_END: begin
               ctrl.load = 1'b1;
            end
            default: begin
               ctrl.load = 1'b1;
            end
         endcase
      end
   end

   // bit zero of the row lives here; no text byte leaves it reachable
   always_comb begin
      reach0_in = reach0_ff;
      if (ctrl.load) begin
         reach0_in = 1'b1;
      end else if (ctrl.step) begin
         reach0_in = 1'b0;
      end
   end

   assign row[0]   = reach0_ff;
   assign carry[0] = 1'b0;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      localparam logic [LEN_W-1:0] IDX  = LEN_W'(j);
      localparam logic [LEN_W-1:0] POS1 = LEN_W'(j + 1);
      wmr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .wr_en      (fire && (act == ACT_APPEND) && (len_ff == IDX)),
         .active     (len_ff > IDX),
         .init_bit   (lead_in >= POS1),
         .reach_left (row[j]),
         .carry_in   (carry[j]),
         .reach      (row[j+1]),
         .carry_out  (carry[j+1])
      );
   end

   assign match_now = row[len_ff];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && (act == ACT_END)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         lead_ff      <= '0;
         all_star_ff  <= 1'b1;
         ovf_ff       <= 1'b0;
         reach0_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         lead_ff      <= lead_in;
         all_star_ff  <= all_star_in;
         ovf_ff       <= ovf_in;
         reach0_ff    <= reach0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && (act == ACT_END)) begin
         rsp_match_ff <= match_now;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_match_ff};

endmodule

/* hw/rtl/wmr_cell.sv */
module wmr_cell
   import wmr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          wr_en,
   input  logic          active,
   input  logic          init_bit,
   input  logic          reach_left,
   input  logic          carry_in,
   output logic          reach,
   output logic          carry_out
);

   logic [SYM_W-1:0] sym_ff;
   logic             reach_ff;
   logic             reach_in;
   logic             is_star;
   logic             sym_hit;

   assign is_star = (sym_ff == STAR_SYM);
   assign sym_hit = (sym_ff == QMARK_SYM) || (sym_ff == ctrl.sym);

   // a star passes reachability on to its right neighbor, like a carry
   always_comb begin
      carry_out = 1'b0;
      if (active) begin
         if (is_star) begin
            carry_out = reach_ff | carry_in;
         end else if (sym_hit) begin
            carry_out = reach_left;
         end
      end
   end

   always_comb begin
      reach_in = reach_ff;
      if (ctrl.load) begin
         reach_in = init_bit;
      end else if (ctrl.step) begin
         reach_in = carry_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= 1'b0;
      end else begin
         reach_ff <= reach_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sym_ff <= ctrl.sym;
      end
   end

   assign reach = reach_ff;

endmodule

/* hw/rtl/wmr_checker.sv */
module wmr_checker
   import wmr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic req_beat;
   logic end_beat;
   logic clear_beat;

   assign req_beat   = req_tvalid && req_tready;
   assign end_beat   = req_beat && (req_tuser == ACT_END);
   assign clear_beat = req_beat && (req_tuser == ACT_CLEAR);

   // a result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped before it was taken");

   // a result only appears after an end-of-text beat
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(end_beat))
      else $error("result beat without an end-of-text beat");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // empty pattern against empty text matches, nothing overflowed
   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      clear_beat ##1 end_beat |=> rsp_tvalid && rsp_tdata[0] && !rsp_tdata[1])
      else $error("empty pattern did not match empty text");

endmodule

bind wildcard_match_row_update wmr_checker u_wmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
